// File: hw/rtl/wds_pkg.sv
// wds_pkg: shared types and constants for the windowed deficit sum block
// request and result payload structs, field widths and parameter defaults
// no dependencies
package wds_pkg;

  localparam int MAX_WINDOW_DEF  = 256;
  localparam int SAMPLE_BITS_DEF = 12;

  localparam int SAMPLE_W   = 12;
  localparam int WINDOW_W   = 9;
  localparam int SUM_OUT_W  = 21;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 9'd30;

  typedef struct packed {
    logic [SAMPLE_W-1:0] transp_potential;
    logic                potential_valid;
    logic [SAMPLE_W-1:0] transp_actual;
    logic                actual_valid;
    logic                series_start;
  } wds_in_t;

  typedef struct packed {
    logic signed [SUM_OUT_W-1:0] window_sum;
    logic                        sum_valid;
  } wds_out_t;

endpackage

// File: hw/rtl/windowed_deficit_sum.sv
// windowed_deficit_sum: moving-window sum of daily transpiration deficits with missing days
// ring store, running sum, missing count, output register with skid stage
// depends on wds_pkg
//
//   channel   handshake                payload
//   in        in_valid / in_ready      in_data  (wds_in_t)
//   out       out_valid / out_ready    out_data (wds_out_t)
//   cfg       cfg_write                cfg_data (window_days)
//
// one request per cycle while in_ready is high; results are registered at the output
// the ring entry leaving the window is prefetched for the next request from the registered
// memory read port, with a bypass when that entry is being written in the same cycle
// rst is synchronous; it restores window_days to 30 and empties the window, no clearing pass
// output register plus skid stage: in_ready drops only when both hold results
module windowed_deficit_sum
  import wds_pkg::*;
#(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  wds_in_t             in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output wds_out_t            out_data,
  input  logic                cfg_write,
  input  logic [WINDOW_W-1:0] cfg_data
);

  localparam int AW     = $clog2(MAX_WINDOW);
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int D_W    = SAMPLE_BITS + 1;
  localparam int ENT_W  = D_W + 1;
  localparam int ACC_W  = SAMPLE_BITS + CNT_W + 1;
  localparam int TAKE_W = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam int CMP_W  = (CNT_W > WINDOW_W) ? CNT_W : WINDOW_W;
  localparam int SAT_W  = (ACC_W > SUM_OUT_W) ? ACC_W : SUM_OUT_W;

  localparam logic signed [SAT_W-1:0] OUT_MAX =
    {{(SAT_W-SUM_OUT_W+1){1'b0}}, {(SUM_OUT_W-1){1'b1}}};
  localparam logic signed [SAT_W-1:0] OUT_MIN =
    {{(SAT_W-SUM_OUT_W+1){1'b1}}, {(SUM_OUT_W-1){1'b0}}};

  // ring store
  logic [ENT_W-1:0] ring [MAX_WINDOW];

  // registers
  logic [WINDOW_W-1:0]     window_days;
  logic [AW-1:0]           wp;
  logic signed [ACC_W-1:0] running_sum;
  logic [CNT_W-1:0]        missing;
  logic [CNT_W-1:0]        days_seen;
  logic [ENT_W-1:0]        rd_q;
  logic [ENT_W-1:0]        fwd_data;
  logic                    fwd;
  logic                    skid_valid;
  wds_out_t                skid_data;

  // next values and datapath
  logic [CMP_W-1:0]        w_ext;
  logic [CNT_W-1:0]        win;
  logic                    accept;
  logic [AW-1:0]           base;
  logic [AW-1:0]           wp_inc;
  logic [AW-1:0]           wp_next;
  logic [CNT_W:0]          rd_diff;
  logic [AW-1:0]           rd_addr;
  logic [SAMPLE_BITS-1:0]  pot;
  logic [SAMPLE_BITS-1:0]  act;
  logic                    miss;
  logic signed [D_W-1:0]   deficit;
  logic [ENT_W-1:0]        old_entry;
  logic signed [D_W-1:0]   old_val;
  logic                    old_miss;
  logic [CNT_W-1:0]        ds_b;
  logic signed [ACC_W-1:0] sum_b;
  logic [CNT_W-1:0]        miss_b;
  logic                    full;
  logic signed [ACC_W-1:0] sum_next;
  logic [CNT_W-1:0]        missing_next;
  logic [CNT_W-1:0]        days_seen_next;
  logic                    valid_next;
  logic signed [SAT_W-1:0] sum_wide;
  logic signed [SAT_W-1:0] sum_sat;
  wds_out_t                result;

  assign in_ready = !skid_valid;
  assign accept   = in_valid && in_ready;

  // effective window length
  always_comb begin
    w_ext = CMP_W'(window_days);
    if (window_days == '0) begin
      win = CNT_W'(1);
    end else if (w_ext > CMP_W'(MAX_WINDOW)) begin
      win = CNT_W'(MAX_WINDOW);
    end else begin
      win = CNT_W'(w_ext);
    end
  end

  // write pointer and prefetch address for the next request
  always_comb begin
    base    = in_data.series_start ? '0 : wp;
    wp_inc  = (base == AW'(MAX_WINDOW - 1)) ? '0 : base + AW'(1);
    if (cfg_write) begin
      wp_next = '0;
    end else if (accept) begin
      wp_next = wp_inc;
    end else begin
      wp_next = wp;
    end
    rd_diff = (CNT_W+1)'(wp_next) - (CNT_W+1)'(win);
    if (rd_diff[CNT_W]) begin
      rd_diff = rd_diff + (CNT_W+1)'(MAX_WINDOW);
    end
    rd_addr = rd_diff[AW-1:0];
  end

  // per-day update
  always_comb begin
    pot      = SAMPLE_BITS'(in_data.transp_potential[TAKE_W-1:0]);
    act      = SAMPLE_BITS'(in_data.transp_actual[TAKE_W-1:0]);
    miss     = !(in_data.potential_valid && in_data.actual_valid);
    deficit  = miss ? '0 : $signed({1'b0, pot}) - $signed({1'b0, act});

    old_entry = fwd ? fwd_data : rd_q;
    old_val   = $signed(old_entry[D_W-1:0]);
    old_miss  = old_entry[D_W];

    ds_b   = in_data.series_start ? '0 : days_seen;
    sum_b  = in_data.series_start ? '0 : running_sum;
    miss_b = in_data.series_start ? '0 : missing;

    full = (ds_b >= win);
    if (full) begin
      sum_next       = sum_b - ACC_W'(old_val);
      missing_next   = miss_b - CNT_W'(old_miss && (miss_b != '0));
      days_seen_next = ds_b;
    end else begin
      sum_next       = sum_b;
      missing_next   = miss_b;
      days_seen_next = ds_b + CNT_W'(1);
    end
    sum_next     = sum_next + ACC_W'(deficit);
    missing_next = missing_next + CNT_W'(miss);

    valid_next = (days_seen_next >= win) && (missing_next == '0);
    sum_wide   = SAT_W'(sum_next);
    if (!valid_next) begin
      sum_sat = '0;
    end else if (sum_wide > OUT_MAX) begin
      sum_sat = OUT_MAX;
    end else if (sum_wide < OUT_MIN) begin
      sum_sat = OUT_MIN;
    end else begin
      sum_sat = sum_wide;
    end
    result.window_sum = sum_sat[SUM_OUT_W-1:0];
    result.sum_valid  = valid_next;
  end

  // ring memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      ring[base] <= {miss, deficit};
    end
    rd_q     <= ring[rd_addr];
    fwd      <= accept && (rd_addr == base);
    fwd_data <= {miss, deficit};
  end

  // window state
  always_ff @(posedge clk) begin
    if (rst) begin
      window_days <= WINDOW_RESET;
      wp          <= '0;
      running_sum <= '0;
      missing     <= '0;
      days_seen   <= '0;
    end else if (cfg_write) begin
      window_days <= cfg_data;
      wp          <= '0;
      running_sum <= '0;
      missing     <= '0;
      days_seen   <= '0;
    end else if (accept) begin
      wp          <= wp_next;
      running_sum <= sum_next;
      missing     <= missing_next;
      days_seen   <= days_seen_next;
    end
  end

  // output register and skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (accept) begin
        out_data <= result;
      end
    end else if (accept) begin
      skid_data <= result;
    end
  end

endmodule
